### rtl/core/event_record_ring_log_defines.svh
// assertion macros shared by the event record ring log checkers
`ifndef EVENT_RECORD_RING_LOG_DEFINES_SVH
`define EVENT_RECORD_RING_LOG_DEFINES_SVH

// same-cycle implication, masked while in reset
`define ERL_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("erl checker: same-cycle property failed");

// next-cycle implication, masked while in reset
`define ERL_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("erl checker: next-cycle property failed");

// next-cycle implication that also holds across reset
`define ERL_ASSERT_ALWAYS(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("erl checker: reset property failed");

`endif

### rtl/core/erl_pkg.sv
// shared types, widths and codes of the event record ring log
package erl_pkg;

  localparam int CAPACITY   = 64;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int MODE_W  = 3;
  localparam int TYPE_W  = 2;
  localparam int WORD_W  = 32;
  localparam int LIDX_W  = 6;
  localparam int FILL_W  = 7;
  localparam int STAT_W  = 2;

  localparam logic [MODE_W-1:0] MODE_APPEND      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_READ_NEWEST = 3'd1;
  localparam logic [MODE_W-1:0] MODE_READ_INDEX  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PAGE_NEWEST = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PAGE_SEQ    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR       = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [2:0] {
    OP_APPEND,
    OP_READ_NEWEST,
    OP_READ_INDEX,
    OP_PAGE_NEWEST,
    OP_PAGE_SEQ,
    OP_CLEAR,
    OP_BAD_COUNT
  } op_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TYPE_W-1:0] event_type;
    logic [WORD_W-1:0] payload;
    logic [LIDX_W-1:0] record_index;
    logic [LIDX_W-1:0] skip_newest;
    logic [WORD_W-1:0] seq_floor;
    logic [FILL_W-1:0] page_limit;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] sequence_res;
    logic [TYPE_W-1:0] record_type;
    logic [WORD_W-1:0] payload_out;
    logic [FILL_W-1:0] fill_count;
    logic [WORD_W-1:0] append_total;
    logic              last;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [TYPE_W-1:0] event_type;
    logic [WORD_W-1:0] payload;
    logic [LIDX_W-1:0] record_index;
    logic [LIDX_W-1:0] skip_newest;
    logic [WORD_W-1:0] seq_floor;
    logic [FILL_W-1:0] page_limit;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] seq;
    logic [TYPE_W-1:0] rtype;
    logic [WORD_W-1:0] payload;
  } record_t;

endpackage

### rtl/core/erl_in_if.sv
// input channel: valid/ready handshake carrying one log request
interface erl_in_if import erl_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### rtl/core/erl_out_if.sv
// result channel: valid/ready handshake carrying one log result
interface erl_out_if import erl_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### rtl/core/erl_front.sv
// front end: accepts requests, decodes the mode and queues a command
module erl_front import erl_pkg::*; (
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     push_valid,
  input  logic     push_ready,
  output cmd_t     push_data
);

  logic keep;
  logic zero_count;

  assign zero_count = (in_data.page_limit == '0);

  always_comb begin
    keep         = 1'b1;
    push_data    = '{op: OP_APPEND,
                     event_type: in_data.event_type,
                     payload: in_data.payload,
                     record_index: in_data.record_index,
                     skip_newest: in_data.skip_newest,
                     seq_floor: in_data.seq_floor,
                     page_limit: in_data.page_limit};
    unique case (in_data.mode)
      MODE_APPEND:      push_data.op = OP_APPEND;
      MODE_READ_NEWEST: push_data.op = OP_READ_NEWEST;
      MODE_READ_INDEX:  push_data.op = OP_READ_INDEX;
      MODE_PAGE_NEWEST: push_data.op = zero_count ? OP_BAD_COUNT : OP_PAGE_NEWEST;
      MODE_PAGE_SEQ:    push_data.op = zero_count ? OP_BAD_COUNT : OP_PAGE_SEQ;
      MODE_CLEAR:       push_data.op = OP_CLEAR;
      // unused modes are taken and dropped
      default:          keep = 1'b0;
    endcase
  end

  assign in_ready   = push_ready;
  assign push_valid = in_valid && push_ready && keep;

endmodule

### rtl/core/erl_cmd_fifo.sv
// short command queue between the front end and the log engine
module erl_cmd_fifo import erl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_data
);

  cmd_t                  slots_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r;
  logic                  do_push;
  logic                  do_pop;

  function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
    return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
  endfunction

  assign push_ready = (count_r != FIFO_CNT_W'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + FIFO_CNT_W'(1);
        2'b01:   count_r <= count_r - FIFO_CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
    if (do_push) slots_r[wr_ptr_r] <= push_data;
  end

endmodule

### rtl/core/erl_back.sv
// log engine: record memory, ring pointers, reads, page walks and search
module erl_back import erl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_pop,
  input  cmd_t      q_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [1:0] {S_IDLE, S_EMIT, S_SEARCH, S_MISS} state_t;

  localparam int SUM_W = IDX_W + 1;

  record_t mem [CAPACITY];
  record_t rd_data_r;

  state_t            state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [WORD_W-1:0] seq_r, seq_nxt;
  logic [WORD_W-1:0] total_r, total_nxt;
  cmd_t              cur_r, cur_nxt;
  logic [IDX_W-1:0]  slot_r, slot_nxt;
  logic [CNT_W-1:0]  remain_r, remain_nxt;
  logic [IDX_W-1:0]  srch_r, srch_nxt;
  logic              down_r, down_nxt;

  logic              out_free;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  oldest;
  logic [FILL_W-1:0] held7;
  logic [FILL_W-1:0] avail;
  logic [FILL_W-1:0] logical;
  logic [IDX_W-1:0]  step_slot;

  function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= SUM_W'(CAPACITY)) s = s - SUM_W'(CAPACITY);
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] a);
    return (a == IDX_W'(CAPACITY - 1)) ? '0 : a + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] slot_dec(input logic [IDX_W-1:0] a);
    return (a == '0) ? IDX_W'(CAPACITY - 1) : a - IDX_W'(1);
  endfunction

  function automatic logic [FILL_W-1:0] min7(input logic [FILL_W-1:0] a,
                                            input logic [FILL_W-1:0] b);
    return (a > b) ? b : a;
  endfunction

  function automatic out_item_t no_record(input logic [STAT_W-1:0] st,
                                          input logic [FILL_W-1:0] fill,
                                          input logic [WORD_W-1:0] total);
    return '{status: st, sequence_res: '0, record_type: '0, payload_out: '0,
             fill_count: fill, append_total: total, last: 1'b1};
  endfunction

  assign oldest   = (held_r == CNT_W'(CAPACITY)) ? head_r : '0;
  assign held7    = FILL_W'(held_r);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    head_nxt      = head_r;
    held_nxt      = held_r;
    seq_nxt       = seq_r;
    total_nxt     = total_r;
    cur_nxt       = cur_r;
    slot_nxt      = slot_r;
    remain_nxt    = remain_r;
    srch_nxt      = srch_r;
    down_nxt      = down_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = slot_r;
    wr_en         = 1'b0;
    avail         = held7 - FILL_W'(q_data.skip_newest);
    logical       = held7 - FILL_W'(1) - FILL_W'(q_data.skip_newest);
    step_slot     = down_r ? slot_dec(slot_r) : slot_inc(slot_r);

    unique case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop   = 1'b1;
          cur_nxt = q_data;
          unique case (q_data.op)
            OP_APPEND: begin
              wr_en     = 1'b1;
              head_nxt  = slot_inc(head_r);
              held_nxt  = (held_r == CNT_W'(CAPACITY)) ? held_r : held_r + CNT_W'(1);
              seq_nxt   = seq_r + WORD_W'(1);
              total_nxt = total_r + WORD_W'(1);
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{status: ST_OK, sequence_res: seq_r,
                                record_type: q_data.event_type,
                                payload_out: q_data.payload,
                                fill_count: FILL_W'(held_nxt),
                                append_total: total_nxt, last: 1'b1};
            end
            OP_READ_NEWEST: begin
              if (held_r == '0) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = no_record(ST_EMPTY, held7, total_r);
              end else begin
                rd_en      = 1'b1;
                rd_addr    = slot_dec(head_r);
                remain_nxt = CNT_W'(1);
                state_nxt  = S_EMIT;
              end
            end
            OP_READ_INDEX: begin
              if (FILL_W'(q_data.record_index) >= held7) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = no_record(ST_RANGE, held7, total_r);
              end else begin
                rd_en      = 1'b1;
                rd_addr    = slot_add(oldest, q_data.record_index[IDX_W-1:0]);
                remain_nxt = CNT_W'(1);
                state_nxt  = S_EMIT;
              end
            end
            OP_PAGE_NEWEST: begin
              if (FILL_W'(q_data.skip_newest) >= held7) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = no_record(ST_EMPTY, held7, total_r);
              end else begin
                rd_en      = 1'b1;
                rd_addr    = slot_add(oldest, logical[IDX_W-1:0]);
                remain_nxt = CNT_W'(min7(avail, q_data.page_limit));
                down_nxt   = 1'b1;
                state_nxt  = S_EMIT;
              end
            end
            OP_PAGE_SEQ: begin
              if (held_r == '0) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = no_record(ST_EMPTY, held7, total_r);
              end else begin
                rd_en     = 1'b1;
                rd_addr   = oldest;
                srch_nxt  = '0;
                down_nxt  = 1'b0;
                state_nxt = S_SEARCH;
              end
            end
            OP_CLEAR: begin
              head_nxt  = '0;
              held_nxt  = '0;
              seq_nxt   = WORD_W'(1);
              total_nxt = '0;
              out_valid_nxt = 1'b1;
              out_data_nxt  = no_record(ST_OK, '0, '0);
            end
            OP_BAD_COUNT: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = no_record(ST_RANGE, held7, total_r);
            end
            default: ;
          endcase
          if (rd_en) slot_nxt = rd_addr;
        end
      end
      S_EMIT: begin
        // rd_data_r holds the record at slot_r; the next read goes out with this result
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_OK, sequence_res: rd_data_r.seq,
                            record_type: rd_data_r.rtype, payload_out: rd_data_r.payload,
                            fill_count: held7, append_total: total_r,
                            last: (remain_r == CNT_W'(1))};
          if (remain_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            remain_nxt = remain_r - CNT_W'(1);
            rd_en      = 1'b1;
            rd_addr    = step_slot;
            slot_nxt   = step_slot;
          end
        end
      end
      S_SEARCH: begin
        if (rd_data_r.seq >= cur_r.seq_floor) begin
          remain_nxt = CNT_W'(min7(held7 - FILL_W'(srch_r), cur_r.page_limit));
          state_nxt  = S_EMIT;
        end else if (FILL_W'(srch_r) == held7 - FILL_W'(1)) begin
          state_nxt = S_MISS;
        end else begin
          srch_nxt = srch_r + IDX_W'(1);
          rd_en    = 1'b1;
          rd_addr  = step_slot;
          slot_nxt = step_slot;
        end
      end
      S_MISS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = no_record(ST_EMPTY, held7, total_r);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[head_r] <= '{seq: seq_r, rtype: q_data.event_type, payload: q_data.payload};
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      held_r      <= '0;
      seq_r       <= WORD_W'(1);
      total_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      held_r      <= held_nxt;
      seq_r       <= seq_nxt;
      total_r     <= total_nxt;
    end
    out_data_r <= out_data_nxt;
    cur_r      <= cur_nxt;
    slot_r     <= slot_nxt;
    remain_r   <= remain_nxt;
    srch_r     <= srch_nxt;
    down_r     <= down_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/event_record_ring_log.sv
// Append, clear and error results: registered in the engine after the command queue.
// Single reads and pages: the first record passes the queue and a registered memory read,
// then one record per cycle from the one-port record memory while results are not stalled.
// Page by sequence walks the ring one entry per cycle before its first record.
// A two-entry command queue lets requests arrive while a page is still going out.
// Synchronous active-low reset clears pointers and counters; record memory is not cleared.
module event_record_ring_log import erl_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  erl_in_if.sink    in_ch,
  erl_out_if.source out_ch
);

  logic push_valid;
  logic push_ready;
  cmd_t push_data;
  logic q_valid;
  logic q_pop;
  cmd_t q_data;

  erl_front u_front (
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_data    (in_ch.data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  erl_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  erl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );

endmodule

### rtl/core/erl_checker.sv
// port-level checker for the event record ring log, bound to the top level
`include "event_record_ring_log_defines.svh"

module erl_checker import erl_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a stalled result holds
  `ERL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // nothing is shown right after reset
  `ERL_ASSERT_ALWAYS(a_reset_quiet, !rst_n, !out_valid)
  // a failing status ends its request and carries no record
  `ERL_ASSERT_SAME(a_fail_empty, out_valid && out_data.status != ST_OK, out_data.last && out_data.sequence_res == '0 && out_data.payload_out == '0)
  // fill never exceeds the ring size
  `ERL_ASSERT_SAME(a_fill_bound, out_valid, out_data.fill_count <= FILL_W'(CAPACITY))

endmodule

bind event_record_ring_log erl_checker u_erl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

### tb/event_record_ring_log_tb.sv
// testbench for the event record ring log: directed table, then random requests vs a ring model
module event_record_ring_log_tb;
  import erl_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t want;
  } row_t;

  typedef struct {
    bit        typed;
    out_item_t want;
  } typed_t;

  logic clk;
  logic rst_n;

  erl_in_if  in_ch();
  erl_out_if out_ch();

  event_record_ring_log u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // ring model state
  bit [WORD_W-1:0] ring_seq  [CAPACITY];
  bit [TYPE_W-1:0] ring_type [CAPACITY];
  bit [WORD_W-1:0] ring_body [CAPACITY];
  int              ring_head     = 0;
  int              ring_fill     = 0;
  bit [WORD_W-1:0] ring_next_seq = 1;
  bit [WORD_W-1:0] ring_total    = 0;

  out_item_t results_due[$];
  typed_t    typed_due[$];
  row_t      directed_rows[$];
  int        errors       = 0;
  bit        steady       = 1'b0;
  bit        hold_off_req = 1'b0;

  function automatic int ring_slot(int logical);
    int oldest;
    oldest = (ring_fill < CAPACITY) ? 0 : ring_head;
    return (oldest + logical) % CAPACITY;
  endfunction

  function automatic void due_result(logic [STAT_W-1:0] st, logic [WORD_W-1:0] seq,
                                     logic [TYPE_W-1:0] rt, logic [WORD_W-1:0] pay, bit last);
    out_item_t r;
    r.status        = st;
    r.sequence_res  = seq;
    r.record_type   = rt;
    r.payload_out   = pay;
    r.fill_count    = ring_fill[FILL_W-1:0];
    r.append_total  = ring_total;
    r.last          = last;
    results_due.push_back(r);
  endfunction

  function automatic void due_slot(int slot, bit last);
    due_result(ST_OK, ring_seq[slot], ring_type[slot], ring_body[slot], last);
  endfunction

  function automatic void ring_apply(in_item_t r);
    int n;
    int first;
    int slot;
    int off;
    int cnt;
    int i;
    off = int'(r.skip_newest);
    cnt = int'(r.page_limit);
    case (r.mode)
      MODE_APPEND: begin
        slot            = ring_head;
        ring_seq[slot]  = ring_next_seq;
        ring_type[slot] = r.event_type;
        ring_body[slot] = r.payload;
        ring_next_seq   = ring_next_seq + 1;
        ring_head       = (slot + 1) % CAPACITY;
        if (ring_fill < CAPACITY) ring_fill++;
        ring_total = ring_total + 1;
        due_result(ST_OK, ring_seq[slot], r.event_type, r.payload, 1'b1);
      end
      MODE_READ_NEWEST: begin
        if (ring_fill == 0) due_result(ST_EMPTY, '0, '0, '0, 1'b1);
        else due_slot((ring_head + CAPACITY - 1) % CAPACITY, 1'b1);
      end
      MODE_READ_INDEX: begin
        if (int'(r.record_index) >= ring_fill) due_result(ST_RANGE, '0, '0, '0, 1'b1);
        else due_slot(ring_slot(int'(r.record_index)), 1'b1);
      end
      MODE_PAGE_NEWEST: begin
        if (cnt == 0) begin
          due_result(ST_RANGE, '0, '0, '0, 1'b1);
        end else if (off >= ring_fill) begin
          due_result(ST_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          n = ring_fill - off;
          if (n > cnt) n = cnt;
          for (i = 0; i < n; i++) due_slot(ring_slot(ring_fill - 1 - off - i), i == n - 1);
        end
      end
      MODE_PAGE_SEQ: begin
        if (cnt == 0) begin
          due_result(ST_RANGE, '0, '0, '0, 1'b1);
        end else begin
          // first oldest-first entry at or above the start, unsigned compare
          first = ring_fill;
          for (i = 0; i < ring_fill; i++)
            if (first == ring_fill && ring_seq[ring_slot(i)] >= r.seq_floor) first = i;
          if (first >= ring_fill) begin
            due_result(ST_EMPTY, '0, '0, '0, 1'b1);
          end else begin
            n = ring_fill - first;
            if (n > cnt) n = cnt;
            for (i = 0; i < n; i++) due_slot(ring_slot(first + i), i == n - 1);
          end
        end
      end
      MODE_CLEAR: begin
        ring_head     = 0;
        ring_fill     = 0;
        ring_next_seq = 1;
        ring_total    = 0;
        due_result(ST_OK, '0, '0, '0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic in_item_t mk_req(logic [MODE_W-1:0] mode, logic [TYPE_W-1:0] et,
                                      logic [WORD_W-1:0] pay, logic [LIDX_W-1:0] ridx,
                                      logic [LIDX_W-1:0] offs, logic [WORD_W-1:0] start,
                                      logic [FILL_W-1:0] maxc);
    in_item_t r;
    r.mode         = mode;
    r.event_type   = et;
    r.payload      = pay;
    r.record_index = ridx;
    r.skip_newest  = offs;
    r.seq_floor    = start;
    r.page_limit   = maxc;
    return r;
  endfunction

  function automatic out_item_t mk_res(logic [STAT_W-1:0] st, logic [WORD_W-1:0] seq,
                                       logic [TYPE_W-1:0] rt, logic [WORD_W-1:0] pay,
                                       int fill, int total);
    out_item_t r;
    r.status        = st;
    r.sequence_res  = seq;
    r.record_type   = rt;
    r.payload_out   = pay;
    r.fill_count    = fill[FILL_W-1:0];
    r.append_total  = total[WORD_W-1:0];
    r.last          = 1'b1;
    return r;
  endfunction

  function automatic int pick_wait();
    if (steady) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  // mostly requests that land inside the held window, some anywhere
  function automatic in_item_t random_request(bit append_only);
    in_item_t        r;
    int              pick;
    int              reach;
    bit [WORD_W-1:0] lo;
    reach = (ring_fill > 63) ? 63 : ring_fill;
    lo = (ring_next_seq > ring_fill + 2) ? ring_next_seq - ring_fill - 2 : '0;
    r.mode         = MODE_APPEND;
    r.event_type   = TYPE_W'($urandom_range(0, 3));
    r.payload      = $urandom;
    r.record_index = ($urandom_range(0, 2) == 0) ? LIDX_W'($urandom_range(0, 63))
                                                 : LIDX_W'($urandom_range(0, reach));
    r.skip_newest  = ($urandom_range(0, 2) == 0) ? LIDX_W'($urandom_range(0, 63))
                                                 : LIDX_W'($urandom_range(0, reach));
    r.page_limit   = ($urandom_range(0, 3) == 0) ? FILL_W'($urandom_range(0, 127))
                                                 : FILL_W'($urandom_range(1, 8));
    r.seq_floor    = ($urandom_range(0, 4) == 0) ? $urandom
                                                 : lo + $urandom_range(0, ring_fill + 4);
    if (!append_only) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)      r.mode = MODE_APPEND;
      else if (pick < 45) r.mode = MODE_READ_NEWEST;
      else if (pick < 60) r.mode = MODE_READ_INDEX;
      else if (pick < 75) r.mode = MODE_PAGE_NEWEST;
      else if (pick < 92) r.mode = MODE_PAGE_SEQ;
      else if (pick < 96) r.mode = MODE_CLEAR;
      else if (pick < 98) r.mode = MODE_SPARE_LO;
      else                r.mode = MODE_SPARE_HI;
    end
    return r;
  endfunction

  function automatic bit field_ok(string name, logic [WORD_W-1:0] want,
                                  logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic offer(in_item_t r, bit typed, out_item_t want);
    int     gap;
    typed_t t;
    gap = pick_wait();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    t.typed = typed;
    t.want  = want;
    @(negedge clk);
    typed_due.push_back(t);
    in_ch.data  <= r;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // prediction on each request transaction, checking on each result transaction
  always @(posedge clk) begin
    typed_t    t;
    out_item_t want;
    bit        ok;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      t = typed_due.pop_front();
      ring_apply(in_ch.data);
      if (t.typed) results_due[results_due.size() - 1] = t.want;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_ch.data);
        errors++;
      end else begin
        want = results_due.pop_front();
        ok = field_ok("status", WORD_W'(want.status), WORD_W'(out_ch.data.status));
        ok &= field_ok("sequence_res", want.sequence_res, out_ch.data.sequence_res);
        ok &= field_ok("record_type", WORD_W'(want.record_type),
                       WORD_W'(out_ch.data.record_type));
        ok &= field_ok("payload_out", want.payload_out, out_ch.data.payload_out);
        ok &= field_ok("fill_count", WORD_W'(want.fill_count),
                       WORD_W'(out_ch.data.fill_count));
        ok &= field_ok("append_total", want.append_total, out_ch.data.append_total);
        ok &= field_ok("last", WORD_W'(want.last), WORD_W'(out_ch.data.last));
        if (!ok) errors++;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stall = pick_wait();
        if (stall > 0) begin
          @(negedge clk);
          out_ch.ready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
        end
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;

    directed_rows.push_back('{mk_req(MODE_READ_NEWEST, 0, 0, 0, 0, 0, 1), 1'b1,
                              mk_res(ST_EMPTY, 0, 0, 0, 0, 0)});
    directed_rows.push_back('{mk_req(MODE_READ_INDEX, 0, 0, 63, 0, 0, 1), 1'b1,
                              mk_res(ST_RANGE, 0, 0, 0, 0, 0)});
    directed_rows.push_back('{mk_req(MODE_PAGE_NEWEST, 0, 0, 0, 0, 0, 0), 1'b1,
                              mk_res(ST_RANGE, 0, 0, 0, 0, 0)});
    directed_rows.push_back('{mk_req(MODE_PAGE_SEQ, 0, 0, 0, 0, 0, 64), 1'b1,
                              mk_res(ST_EMPTY, 0, 0, 0, 0, 0)});
    directed_rows.push_back('{mk_req(MODE_PAGE_NEWEST, 0, 0, 0, 0, 0, 1), 1'b1,
                              mk_res(ST_EMPTY, 0, 0, 0, 0, 0)});
    directed_rows.push_back('{mk_req(MODE_SPARE_LO, 3, '1, 63, 63, '1, 127), 1'b0, '0});
    directed_rows.push_back('{mk_req(MODE_APPEND, 0, 0, 0, 0, 0, 0), 1'b1,
                              mk_res(ST_OK, 1, 0, 0, 1, 1)});
    // type 3 is stored as given
    directed_rows.push_back('{mk_req(MODE_APPEND, 3, 32'hFFFF_FFFF, 0, 0, 0, 0), 1'b1,
                              mk_res(ST_OK, 2, 3, 32'hFFFF_FFFF, 2, 2)});
    directed_rows.push_back('{mk_req(MODE_APPEND, 1, 32'hA5A5_5A5A, 0, 0, 0, 0), 1'b1,
                              mk_res(ST_OK, 3, 1, 32'hA5A5_5A5A, 3, 3)});
    directed_rows.push_back('{mk_req(MODE_APPEND, 2, 32'h0000_0001, 0, 0, 0, 0), 1'b1,
                              mk_res(ST_OK, 4, 2, 32'h0000_0001, 4, 4)});
    directed_rows.push_back('{mk_req(MODE_READ_NEWEST, 0, 0, 0, 0, 0, 1), 1'b1,
                              mk_res(ST_OK, 4, 2, 32'h0000_0001, 4, 4)});
    directed_rows.push_back('{mk_req(MODE_READ_INDEX, 0, 0, 0, 0, 0, 1), 1'b1,
                              mk_res(ST_OK, 1, 0, 0, 4, 4)});
    directed_rows.push_back('{mk_req(MODE_READ_INDEX, 0, 0, 4, 0, 0, 1), 1'b1,
                              mk_res(ST_RANGE, 0, 0, 0, 4, 4)});
    directed_rows.push_back('{mk_req(MODE_PAGE_NEWEST, 0, 0, 0, 63, 0, 1), 1'b1,
                              mk_res(ST_EMPTY, 0, 0, 0, 4, 4)});
    directed_rows.push_back('{mk_req(MODE_PAGE_NEWEST, 0, 0, 0, 0, 0, 127), 1'b0, '0});
    directed_rows.push_back('{mk_req(MODE_PAGE_NEWEST, 0, 0, 0, 1, 0, 2), 1'b0, '0});
    directed_rows.push_back('{mk_req(MODE_PAGE_SEQ, 0, 0, 0, 0, 3, 64), 1'b0, '0});
    directed_rows.push_back('{mk_req(MODE_PAGE_SEQ, 0, 0, 0, 0, 32'hFFFF_FFFF, 1), 1'b1,
                              mk_res(ST_EMPTY, 0, 0, 0, 4, 4)});
    directed_rows.push_back('{mk_req(MODE_PAGE_SEQ, 0, 0, 0, 0, 0, 0), 1'b1,
                              mk_res(ST_RANGE, 0, 0, 0, 4, 4)});
    directed_rows.push_back('{mk_req(MODE_PAGE_SEQ, 0, 0, 0, 0, 0, 127), 1'b0, '0});
    directed_rows.push_back('{mk_req(MODE_SPARE_HI, 3, '1, 63, 63, '1, 127), 1'b0, '0});
    directed_rows.push_back('{mk_req(MODE_CLEAR, 3, '1, 63, 63, '1, 127), 1'b1,
                              mk_res(ST_OK, 0, 0, 0, 0, 0)});
    directed_rows.push_back('{mk_req(MODE_READ_NEWEST, 0, 0, 0, 0, 0, 1), 1'b1,
                              mk_res(ST_EMPTY, 0, 0, 0, 0, 0)});
    // numbering restarts after clear
    directed_rows.push_back('{mk_req(MODE_APPEND, 2, 32'h8000_0001, 0, 0, 0, 0), 1'b1,
                              mk_res(ST_OK, 1, 2, 32'h8000_0001, 1, 1)});
    directed_rows.push_back('{mk_req(MODE_READ_INDEX, 0, 0, 0, 0, 0, 1), 1'b0, '0});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k])
      offer(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);

    // appends pour in while the result side holds off; the ring wraps past capacity
    steady       = 1'b1;
    hold_off_req = 1'b1;
    repeat (66) offer(random_request(1'b1), 1'b0, '0);

    for (int k = 0; k < 20; k++) begin
      if (k % 10 == 0) steady = ($urandom_range(0, 2) == 0);
      offer(random_request(1'b0), 1'b0, '0);
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && results_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
